@@ rtl/core/vlmra_pkg.sv @@
// shared types and constants for the variable-length message ring allocator
// no dependencies; used by vlmra_ctrl, vlmra_dpath and the top level
package vlmra_pkg;

  localparam int ELEM_COUNT = 64;
  localparam int BUF_BYTES  = 4096;

  localparam int ELEM_BITS = $clog2(ELEM_COUNT);
  localparam int CNT_W     = ELEM_BITS + 1;
  localparam int BUF_BITS  = $clog2(BUF_BYTES);
  // byte pointers only need to resolve differences below four ring sizes
  localparam int PTR_W     = BUF_BITS + 2;

  localparam int OP_W     = 2;
  localparam int LEN_W    = 16;
  localparam int ALEN_W   = LEN_W + 1;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;

  localparam int ALIGN_MASK = 7;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_PEEK  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

@@ rtl/core/vlmra_ctrl.sv @@
// controller for the ring allocator: sequences capture and execute
// depends on vlmra_pkg
module vlmra_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output vlmra_pkg::cmd_t cmd
);

  vlmra_pkg::state_t state;
  vlmra_pkg::state_t state_next;
  logic              out_valid_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      vlmra_pkg::S_IDLE: begin
        if (in_valid) state_next = vlmra_pkg::S_EXEC;
      end
      vlmra_pkg::S_EXEC: begin
        if (out_free) state_next = vlmra_pkg::S_IDLE;
      end
      default: state_next = vlmra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      vlmra_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      vlmra_pkg::S_EXEC: begin
        // hold the item until the result register can take it
        cmd.execute = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.execute) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vlmra_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/vlmra_dpath.sv @@
// datapath for the ring allocator: pointers, length fifo memory, placement
// arithmetic and the result register; depends on vlmra_pkg
module vlmra_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  vlmra_pkg::cmd_t                cmd,
  input  logic [vlmra_pkg::OP_W-1:0]     operation,
  input  logic [vlmra_pkg::LEN_W-1:0]    msg_length,
  output logic [vlmra_pkg::STATUS_W-1:0] status,
  output logic [vlmra_pkg::OFF_W-1:0]    byte_offset,
  output logic [vlmra_pkg::LEN_W-1:0]    length_out
);

  localparam int PTR_W    = vlmra_pkg::PTR_W;
  localparam int CNT_W    = vlmra_pkg::CNT_W;
  localparam int BUF_BITS = vlmra_pkg::BUF_BITS;
  localparam int LOW_W    = BUF_BITS + 1;
  localparam int LEN_W    = vlmra_pkg::LEN_W;
  localparam int ALEN_W   = vlmra_pkg::ALEN_W;

  function automatic logic [ALEN_W-1:0] round_len(input logic [LEN_W-1:0] l);
    round_len = (ALEN_W'(l) + ALEN_W'(vlmra_pkg::ALIGN_MASK))
                & ~ALEN_W'(vlmra_pkg::ALIGN_MASK);
  endfunction

  // move to the start of the next lap if the block would straddle the end
  function automatic logic [PTR_W-1:0] place(input logic [PTR_W-1:0]    pos,
                                             input logic [BUF_BITS-1:0] alen);
    logic [LOW_W-1:0] low_end;
    low_end = {1'b0, pos[BUF_BITS-1:0]} + {1'b0, alen};
    if (alen != '0 && low_end > LOW_W'(vlmra_pkg::BUF_BYTES))
      place = (pos | PTR_W'(vlmra_pkg::BUF_BYTES - 1)) + PTR_W'(1);
    else
      place = pos;
  endfunction

  logic [LEN_W-1:0] length_fifo [vlmra_pkg::ELEM_COUNT];
  logic [LEN_W-1:0] rd_data;

  logic [vlmra_pkg::OP_W-1:0] op_q;
  logic [LEN_W-1:0]           len_q;

  logic [CNT_W-1:0] count_head;
  logic [CNT_W-1:0] count_tail;
  logic [PTR_W-1:0] byte_head;
  logic [PTR_W-1:0] byte_tail;
  logic [PTR_W-1:0] byte_head_next;
  logic [PTR_W-1:0] byte_tail_next;

  logic [ALEN_W-1:0]   alen_wr;
  logic [ALEN_W-1:0]   alen_rd;
  logic [BUF_BITS-1:0] alen_tail;
  logic [BUF_BITS-1:0] alen_head;
  logic [PTR_W-1:0]    tail_start;
  logic [PTR_W-1:0]    head_start;
  logic [PTR_W-1:0]    tail_end;
  logic [PTR_W-1:0]    head_end;
  logic                too_large;
  logic                fifo_full;
  logic                fifo_empty;
  logic                ring_short;

  vlmra_pkg::status_t res_status;
  logic [PTR_W-1:0]   res_ptr;
  logic [LEN_W-1:0]   res_length;
  logic               push;
  logic               pop;

  assign alen_wr    = round_len(len_q);
  assign alen_rd    = round_len(rd_data);
  assign alen_tail  = alen_wr[BUF_BITS-1:0];
  assign alen_head  = alen_rd[BUF_BITS-1:0];
  assign too_large  = alen_wr > ALEN_W'(vlmra_pkg::BUF_BYTES - 1);
  assign fifo_full  = (count_tail - count_head) == CNT_W'(vlmra_pkg::ELEM_COUNT);
  assign fifo_empty = count_tail == count_head;
  assign tail_start = place(byte_tail, alen_tail);
  assign head_start = place(byte_head, alen_head);
  assign tail_end   = tail_start + PTR_W'(alen_tail);
  assign head_end   = head_start + PTR_W'(alen_head);
  assign ring_short = (tail_end - byte_head) > PTR_W'(vlmra_pkg::BUF_BYTES);

  always_comb begin
    res_status = vlmra_pkg::ST_OK;
    res_ptr    = '0;
    res_length = '0;
    push       = 1'b0;
    pop        = 1'b0;
    case (op_q)
      vlmra_pkg::OP_WRITE: begin
        if (too_large) begin
          res_status = vlmra_pkg::ST_TOO_LARGE;
        end else if (fifo_full || ring_short) begin
          res_status = vlmra_pkg::ST_NO_SPACE;
        end else begin
          res_ptr = tail_start;
          push    = 1'b1;
        end
      end
      vlmra_pkg::OP_READ: begin
        if (fifo_empty) begin
          res_status = vlmra_pkg::ST_EMPTY;
        end else begin
          res_ptr    = head_start;
          res_length = rd_data;
          pop        = 1'b1;
        end
      end
      default: begin
        // peek, and the unused code behaves as peek
        if (fifo_empty) begin
          res_status = vlmra_pkg::ST_EMPTY;
        end else begin
          res_ptr    = head_start;
          res_length = rd_data;
        end
      end
    endcase
  end

  assign byte_tail_next = (cmd.execute && push) ? tail_end : byte_tail;
  assign byte_head_next = (cmd.execute && pop) ? head_end : byte_head;

  // head entry is read every cycle; the head only moves at the end of an item
  always_ff @(posedge clk) begin
    if (cmd.execute && push) length_fifo[count_tail[vlmra_pkg::ELEM_BITS-1:0]] <= len_q;
    rd_data <= length_fifo[count_head[vlmra_pkg::ELEM_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= operation;
      len_q <= msg_length;
    end
    if (cmd.execute) begin
      status      <= res_status;
      byte_offset <= vlmra_pkg::OFF_W'(res_ptr[BUF_BITS-1:0]);
      length_out  <= res_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_head <= '0;
      count_tail <= '0;
      byte_head  <= '0;
      byte_tail  <= '0;
    end else begin
      if (cmd.execute && push) count_tail <= count_tail + CNT_W'(1);
      if (cmd.execute && pop) count_head <= count_head + CNT_W'(1);
      byte_head <= byte_head_next;
      byte_tail <= byte_tail_next;
    end
  end

endmodule

@@ rtl/core/variable_length_message_ring_allocator.sv @@
// Offset manager for a byte ring of variable-length messages with a 64-entry
// length fifo. Each item is latched in the capture state, which also issues the
// fifo head read, and then placed in the execute state, which updates the
// pointers, so one item is in flight at a time; the single result register
// lets the next item be taken while a result waits, and a result that is not
// taken holds the following item in its execute state. Lengths are rounded up
// to 8 bytes and a message that would run past the ring end starts at the next
// lap. Depends on vlmra_pkg, vlmra_ctrl and vlmra_dpath.
module variable_length_message_ring_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [vlmra_pkg::OP_W-1:0]     operation,
  input  logic [vlmra_pkg::LEN_W-1:0]    msg_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vlmra_pkg::STATUS_W-1:0] status,
  output logic [vlmra_pkg::OFF_W-1:0]    byte_offset,
  output logic [vlmra_pkg::LEN_W-1:0]    length_out
);

  vlmra_pkg::cmd_t cmd;

  vlmra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  vlmra_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .msg_length  (msg_length),
    .status      (status),
    .byte_offset (byte_offset),
    .length_out  (length_out)
  );

  // one item in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // failed operations carry no offset and no length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != vlmra_pkg::ST_OK |-> byte_offset == '0 && length_out == '0)
    else $error("non-ok result with payload");

  // a new result only comes out of the execute cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in execution");

endmodule

@@ tb/sv/vlmra_result_check.sv @@
// result checker for the variable-length message ring allocator: watches both channels,
// predicts every result from its own copy of the ring and fifo pointers, compares fields
// depends on vlmra_pkg for widths, sizes and the operation and status codes
module vlmra_result_check
  import vlmra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [LEN_W-1:0]    msg_length,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] status,
  input  logic [OFF_W-1:0]    byte_offset,
  input  logic [LEN_W-1:0]    length_out,
  input  logic                drain_done,
  output int                  fail_count,
  output int                  pending,
  output int                  n_placed,
  output int                  n_lap_moves,
  output int                  n_too_large,
  output int                  n_no_space,
  output int                  n_empty
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t          st;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } outcome_t;

  localparam logic [31:0] RING_MASK = 32'(BUF_BYTES - 1);

  outcome_t         expected_outcomes[$];
  logic [LEN_W-1:0] stored_len[ELEM_COUNT];
  logic [31:0]      slot_head, slot_tail, ring_head, ring_tail;
  bit               leftover_checked;

  function automatic logic [31:0] align8(input logic [31:0] n);
    return (n + 32'(ALIGN_MASK)) & ~32'(ALIGN_MASK);
  endfunction

  // start of an n-byte block at pos, pushed to the next lap if it would straddle the end
  function automatic logic [31:0] lap_start(input logic [31:0] pos, input logic [31:0] n);
    logic [31:0] end_lap;
    logic [31:0] gap;
    end_lap = (pos + n - 32'd1) & ~RING_MASK;
    gap     = end_lap - (pos & ~RING_MASK);
    // a zero-length block points back a lap, which shows as a negative gap
    return (gap != 32'd0 && !gap[31]) ? end_lap : pos;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] error: %s (got %0d, expected %0d)", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_outcome(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] mlen);
    outcome_t    o;
    logic [31:0] alen;
    logic [31:0] start;
    o = '{ST_OK, '0, '0};
    if (op == OP_WRITE) begin
      alen  = align8(32'(mlen));
      start = lap_start(ring_tail, alen);
      if (alen > RING_MASK) begin
        o.st = ST_TOO_LARGE;
        n_too_large++;
      end else if (slot_tail - slot_head >= 32'(ELEM_COUNT) ||
                   start + alen - ring_head > 32'(BUF_BYTES)) begin
        o.st = ST_NO_SPACE;
        n_no_space++;
      end else begin
        if (start != ring_tail) n_lap_moves++;
        ring_tail = start + alen;
        stored_len[slot_tail[ELEM_BITS-1:0]] = mlen;
        slot_tail++;
        o.off = OFF_W'(start & RING_MASK);
        n_placed++;
      end
    end else if (slot_tail == slot_head) begin
      o.st = ST_EMPTY;
      n_empty++;
    end else begin
      // peek, read and the spare code all report the head; only read pops it
      o.len = stored_len[slot_head[ELEM_BITS-1:0]];
      alen  = align8(32'(o.len));
      start = lap_start(ring_head, alen);
      o.off = OFF_W'(start & RING_MASK);
      if (op == OP_READ) begin
        slot_head++;
        ring_head = start + alen;
      end
    end
    expected_outcomes.push_back(o);
  endtask

  task automatic check_outcome();
    outcome_t o;
    if (expected_outcomes.size() == 0) begin
      report_mismatch("result transfer with nothing outstanding", int'(status), -1);
      return;
    end
    o = expected_outcomes.pop_front();
    if (status !== o.st) report_mismatch("status", int'(status), int'(o.st));
    if (byte_offset !== o.off) report_mismatch("byte_offset", int'(byte_offset), int'(o.off));
    if (length_out !== o.len) report_mismatch("length_out", int'(length_out), int'(o.len));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_outcomes.delete();
      slot_head        = '0;
      slot_tail        = '0;
      ring_head        = '0;
      ring_tail        = '0;
      fail_count       = 0;
      n_placed         = 0;
      n_lap_moves      = 0;
      n_too_large      = 0;
      n_no_space       = 0;
      n_empty          = 0;
      leftover_checked = 1'b0;
    end else begin
      // results belong to earlier transfers, so check before queueing this edge's input
      if (out_valid && out_ready) check_outcome();
      if (in_valid && in_ready) predict_outcome(operation, msg_length);
      if (drain_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_outcomes.size() != 0)
          report_mismatch("results never delivered", 0, expected_outcomes.size());
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

@@ tb/sv/tb_variable_length_message_ring_allocator.sv @@
// testbench top for the variable-length message ring allocator: clock, reset, stimulus,
// random idling on both channels and the verdict
// depends on vlmra_pkg, the allocator rtl and vlmra_result_check
module tb_variable_length_message_ring_allocator;
  import vlmra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, decodes as a peek
  localparam int IDLE_PCT     = 11;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic [OP_W-1:0]     operation  = OP_PEEK;
  logic [LEN_W-1:0]    msg_length = '0;
  logic                out_ready  = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    byte_offset;
  logic [LEN_W-1:0]    length_out;

  logic calm       = 1'b0;
  logic hold_req   = 1'b0;
  logic drain_done = 1'b0;

  int fail_count, pending, n_placed, n_lap_moves, n_too_large, n_no_space, n_empty;
  int unsigned elapsed = 0;

  variable_length_message_ring_allocator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .msg_length  (msg_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .byte_offset (byte_offset),
    .length_out  (length_out)
  );

  vlmra_result_check u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .msg_length  (msg_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .byte_offset (byte_offset),
    .length_out  (length_out),
    .drain_done  (drain_done),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_placed    (n_placed),
    .n_lap_moves (n_lap_moves),
    .n_too_large (n_too_large),
    .n_no_space  (n_no_space),
    .n_empty     (n_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (elapsed < CYCLE_LIMIT) begin
      @(posedge clk);
      elapsed++;
    end
    $display("[%0t] run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request, none while calm
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] mlen);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid   <= 1'b0;
      operation  <= OP_W'($urandom_range(0, 3));
      msg_length <= LEN_W'($urandom());
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    msg_length <= mlen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(0, 300));
    if (r < 85) return LEN_W'($urandom_range(0, BUF_BYTES));
    // around the oversize boundary
    if (r < 95) return LEN_W'($urandom_range(BUF_BYTES - 16, BUF_BYTES + 8));
    return LEN_W'($urandom());
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int unsigned write_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < write_pct) return OP_WRITE;
    r = $urandom_range(0, 19);
    if (r < 13) return OP_READ;
    if (r < 18) return OP_PEEK;
    return OP_SPARE;
  endfunction

  initial begin
    int unsigned done_items;
    int unsigned burst;
    int unsigned write_pct;
    bit          calm_done;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue on every non-write code
    send_item(OP_READ, '0);
    send_item(OP_PEEK, '1);
    send_item(OP_SPARE, '0);
    // zero-length message reserves no bytes
    send_item(OP_WRITE, '0);
    send_item(OP_PEEK, '0);
    send_item(OP_SPARE, '0);
    send_item(OP_READ, '0);
    // rounded length above ring size minus one
    send_item(OP_WRITE, '1);
    send_item(OP_WRITE, 16'd4089);
    // largest legal message, fill the ring exactly, then overflow it
    send_item(OP_WRITE, 16'd4088);
    send_item(OP_WRITE, 16'd1);
    send_item(OP_WRITE, 16'd8);
    send_item(OP_READ, '0);
    send_item(OP_READ, '0);
    // lap moves, first refused for lack of room, then accepted
    send_item(OP_WRITE, 16'd100);
    send_item(OP_WRITE, 16'd4000);
    send_item(OP_READ, '0);
    send_item(OP_WRITE, 16'd3000);
    send_item(OP_WRITE, 16'd1200);
    send_item(OP_READ, '0);
    send_item(OP_WRITE, 16'd1200);
    send_item(OP_PEEK, '0);
    send_item(OP_READ, '0);
    send_item(OP_READ, '0);
    send_item(OP_READ, '0);
    wait_drained();

    // receiver held off while writes keep coming: input stalls, then the fifo runs full
    hold_req <= 1'b1;
    calm     <= 1'b1;
    repeat (72) send_item(OP_WRITE, LEN_W'($urandom_range(0, 15)));
    calm <= 1'b0;
    repeat (72) send_item(OP_READ, '0);
    wait_drained();

    done_items = 0;
    calm_done  = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      burst = $urandom_range(30, 120);
      case ($urandom_range(0, 3))
        0:       write_pct = 25;
        1:       write_pct = 50;
        2:       write_pct = 65;
        default: write_pct = 90;
      endcase
      if (!calm_done && done_items >= 500) begin
        calm_done = 1'b1;
        calm     <= 1'b1;
        burst     = 200;
      end else begin
        calm <= 1'b0;
      end
      repeat (burst) begin
        send_item(pick_op(write_pct), pick_length());
        done_items++;
      end
    end
    calm <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("placed %0d messages, %0d of them moved to the start of the next lap",
             n_placed, n_lap_moves);
    $display("refused %0d oversized and %0d for lack of room; %0d accesses to an empty queue",
             n_too_large, n_no_space, n_empty);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
